### hw/rtl/sorted_timer_queue_unit_assert.svh
// Assertion macros for the sorted timer queue unit.
// Both macros sample on clk_i; the first one is disabled while rst_ni is low.
`ifndef SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH

// Check a property outside of reset.
`define STQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, including during reset.
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Word types and command codes for the sorted timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  // Command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  timer_id;
    logic        periodic;
    logic [31:0] interval_ticks;
    logic [63:0] now_ticks;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic        status;
    logic        fired;
    logic [3:0]  fired_id;
    logic        program_alarm;
    logic [63:0] alarm_time;
    logic        last;
  } out_word_t;

  // One slot table entry held in memory
  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] period;
    logic [31:0] order;
  } slot_ent_t;

endpackage

`default_nettype wire

### hw/rtl/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/sorted_timer_queue_unit.sv
// Scans: a table scan reads every slot in turn through the single RAM read port.
// Add: up to two table scans from accept to result; delete: up to two table scans.
// Tick: one scan per fired word plus one scan for the final word.
// Throughput: one command at a time; ready is high only when the block is idle.
// Reset: clears armed, periodic and scheduled flags, order counter and register;
// the slot RAM needs no clearing since entries are only read once written.
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Deadline-ordered timer queue with a scan sequencer over a slot RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue_unit #(
  parameter int NUM_TIMERS = 16,
  parameter int FIRE_LIMIT = 63
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire stq_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output stq_pkg::out_word_t      out_word_o
);

  import stq_pkg::*;

  `include "sorted_timer_queue_unit_assert.svh"

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam int CNT_W = IDX_W + 1;
  localparam int K_W   = $clog2(FIRE_LIMIT + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDID  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_TCHK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  localparam logic [2:0] PH_MATCH = 3'd0;
  localparam logic [2:0] PH_ADD   = 3'd1;
  localparam logic [2:0] PH_DEL   = 3'd2;
  localparam logic [2:0] PH_TICK  = 3'd3;
  localparam logic [2:0] PH_FINAL = 3'd4;

  logic [2:0]            state_q, state_d, ret_q, ret_d, phase_q, phase_d;
  logic                  match_q, match_d;
  in_word_t              in_q, in_d;
  logic [63:0]           dl_q, dl_d;
  logic [K_W-1:0]        k_q, k_d;
  logic [31:0]           oc_q, oc_d, min_q;
  logic [NUM_TIMERS-1:0] armed_q, armed_d, per_q, per_d, sched_q, sched_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                  best_vld_q, best_vld_d;
  logic [IDX_W-1:0]      best_id_q, best_id_d;
  logic [63:0]           best_dl_q, best_dl_d;
  logic [31:0]           best_age_q, best_age_d, best_per_q, best_per_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  slot_ent_t             ram_wdata, ram_rdata;

  logic                  start_scan, start_match;
  logic [2:0]            start_phase;
  logic [IDX_W-1:0]      tid, in_tid;
  logic                  in_id_ok;
  logic [31:0]           c_age, ival1;
  logic                  c_pass, c_better;
  logic [63:0]           new_dl;

  stq_ram #(
    .WIDTH($bits(slot_ent_t)),
    .DEPTH(NUM_TIMERS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign tid      = IDX_W'(in_q.timer_id);
  assign in_tid   = IDX_W'(in_word_i.timer_id);
  assign in_id_ok = {5'd0, in_word_i.timer_id} < 9'(NUM_TIMERS);
  assign ival1    = (in_word_i.interval_ticks == 32'd0) ? 32'd1 : in_word_i.interval_ticks;
  assign new_dl   = best_dl_q + {32'd0, best_per_q};

  // Candidate ordering against the running best
  assign c_age    = oc_q - ram_rdata.order;
  assign c_pass   = armed_q[cmp_idx_q] &&
                    (!match_q || (per_q[cmp_idx_q] && ram_rdata.period == in_q.interval_ticks));
  assign c_better = !best_vld_q || (ram_rdata.deadline < best_dl_q) ||
                    ((ram_rdata.deadline == best_dl_q) && (c_age > best_age_q));

  // Read address: the addressed slot at command accept, else the scan pointer
  assign ram_raddr = (state_q == S_IDLE) ? in_tid : cnt_q[IDX_W-1:0];

  // Sequencer
  always_comb begin
    state_d = state_q;   ret_d = ret_q;    phase_d = phase_q;  match_d = match_q;
    in_d = in_q;         dl_d = dl_q;      k_d = k_q;          oc_d = oc_q;
    armed_d = armed_q;   per_d = per_q;    sched_d = sched_q;
    cnt_d = cnt_q;       cmp_vld_d = 1'b0; cmp_idx_d = cmp_idx_q;
    best_vld_d = best_vld_q; best_id_d = best_id_q; best_dl_d = best_dl_q;
    best_age_d = best_age_q; best_per_d = best_per_q;
    out_valid_d = out_valid_q; out_d = out_q;
    ram_we = 1'b0; ram_waddr = tid; ram_wdata = '{deadline: dl_q,
                                                  period: in_q.interval_ticks,
                                                  order: oc_q};
    start_scan = 1'b0; start_match = 1'b0; start_phase = PH_FINAL;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_word_i;
          out_d = '0;
          out_d.last = 1'b1;
          if (in_word_i.cmd == CMD_TICK) begin
            k_d = '0;
            state_d = S_TCHK;
          end else if (in_word_i.cmd == CMD_ADD && in_id_ok) begin
            if (in_word_i.periodic && in_word_i.interval_ticks < min_q) begin
              out_d.status = 1'b1;
              out_valid_d = 1'b1;
              ret_d = S_IDLE;
              state_d = S_WAIT;
            end else begin
              armed_d[in_tid] = 1'b0;
              if (!in_word_i.periodic) begin
                dl_d = in_word_i.now_ticks + {32'd0, ival1};
                state_d = S_WRITE;
              end else if (sched_q[in_tid]) begin
                state_d = S_RDID;
              end else begin
                start_scan = 1'b1;
                start_match = 1'b1;
                start_phase = PH_MATCH;
              end
            end
          end else if (in_word_i.cmd == CMD_DEL && in_id_ok) begin
            per_d[in_tid] = 1'b0;
            if (armed_q[in_tid]) begin
              start_scan = 1'b1;
              start_phase = PH_DEL;
            end else begin
              out_valid_d = 1'b1;
              ret_d = S_IDLE;
              state_d = S_WAIT;
            end
          end else begin
            out_valid_d = 1'b1;
            ret_d = S_IDLE;
            state_d = S_WAIT;
          end
        end
      end
      S_RDID: begin
        dl_d = ram_rdata.deadline + {32'd0, in_q.interval_ticks};
        state_d = S_WRITE;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        oc_d = oc_q + 32'd1;
        armed_d[tid] = 1'b1;
        per_d[tid] = in_q.periodic;
        sched_d[tid] = (dl_q != 64'd0);
        start_scan = 1'b1;
        start_phase = PH_ADD;
      end
      S_TCHK: begin
        start_scan = 1'b1;
        start_phase = (k_q == K_W'(FIRE_LIMIT)) ? PH_FINAL : PH_TICK;
      end
      S_SCAN: begin
        // Fold in the entry read last cycle
        if (cmp_vld_q && c_pass && c_better) begin
          best_vld_d = 1'b1;
          best_id_d = cmp_idx_q;
          best_dl_d = ram_rdata.deadline;
          best_age_d = c_age;
          best_per_d = ram_rdata.period;
        end
        // Issue the next read
        if (cnt_q < CNT_W'(NUM_TIMERS)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[IDX_W-1:0];
          cnt_d = cnt_q + CNT_W'(1);
        end else if (!cmp_vld_q) begin
          out_d = '0;
          out_d.last = 1'b1;
          unique case (phase_q)
            PH_MATCH: begin
              dl_d = (best_vld_q ? best_dl_q : in_q.now_ticks) +
                     {32'd0, in_q.interval_ticks};
              state_d = S_WRITE;
            end
            PH_ADD: begin
              if (best_id_q == tid) begin
                out_d.program_alarm = 1'b1;
                out_d.alarm_time = dl_q;
              end
              out_valid_d = 1'b1;
              ret_d = S_IDLE;
              state_d = S_WAIT;
            end
            PH_DEL: begin
              armed_d[tid] = 1'b0;
              if (best_id_q == tid) begin
                start_scan = 1'b1;
                start_phase = PH_FINAL;
              end else begin
                out_valid_d = 1'b1;
                ret_d = S_IDLE;
                state_d = S_WAIT;
              end
            end
            PH_TICK: begin
              if (!best_vld_q || best_dl_q > in_q.now_ticks) begin
                out_d.program_alarm = best_vld_q;
                out_d.alarm_time = best_vld_q ? best_dl_q : 64'd0;
                ret_d = S_IDLE;
              end else begin
                // Fire the head, re-arm it if periodic
                out_d.fired = 1'b1;
                out_d.fired_id = 4'(best_id_q);
                out_d.last = 1'b0;
                armed_d[best_id_q] = per_q[best_id_q];
                if (per_q[best_id_q]) begin
                  ram_we = 1'b1;
                  ram_waddr = best_id_q;
                  ram_wdata = '{deadline: new_dl, period: best_per_q, order: oc_q};
                  oc_d = oc_q + 32'd1;
                  sched_d[best_id_q] = (new_dl != 64'd0);
                end
                k_d = k_q + K_W'(1);
                ret_d = S_TCHK;
              end
              out_valid_d = 1'b1;
              state_d = S_WAIT;
            end
            default: begin
              out_d.program_alarm = best_vld_q;
              out_d.alarm_time = best_vld_q ? best_dl_q : 64'd0;
              out_valid_d = 1'b1;
              ret_d = S_IDLE;
              state_d = S_WAIT;
            end
          endcase
        end
      end
      S_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Begin a table scan
    if (start_scan) begin
      state_d = S_SCAN;
      phase_d = start_phase;
      match_d = start_match;
      cnt_d = '0;
      cmp_vld_d = 1'b0;
      best_vld_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      phase_q <= PH_FINAL;
      match_q <= 1'b0;
      k_q <= '0;
      oc_q <= '0;
      min_q <= '0;
      armed_q <= '0;
      per_q <= '0;
      sched_q <= '0;
      cnt_q <= '0;
      cmp_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      phase_q <= phase_d;
      match_q <= match_d;
      k_q <= k_d;
      oc_q <= oc_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      armed_q <= armed_d;
      per_q <= per_d;
      sched_q <= sched_d;
      cnt_q <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      best_vld_q <= best_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    dl_q <= dl_d;
    cmp_idx_q <= cmp_idx_d;
    best_id_q <= best_id_d;
    best_dl_q <= best_dl_d;
    best_age_q <= best_age_d;
    best_per_q <= best_per_d;
    out_q <= out_d;
  end

  `STQ_ASSERT(a_idle_no_word, in_ready_o |-> !out_valid_o, "result word pending while idle")
  `STQ_ASSERT(a_nonlast_fired, (out_valid_o && !out_word_o.last) |-> out_word_o.fired, "non-final word without fire")
  `STQ_ASSERT(a_alarm_zero, (out_valid_o && !out_word_o.program_alarm) |-> (out_word_o.alarm_time == 64'd0), "alarm time set without program")
  `STQ_ASSERT(a_fire_bound, k_q <= K_W'(FIRE_LIMIT), "fire count past limit")

endmodule

`default_nettype wire

### dv/sorted_timer_queue_unit_checker.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit_checker
// Watches the command and result channels of the timer queue, keeps its own
// copy of the slot table, predicts the result words of every accepted command
// and compares them field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue_unit_checker
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int FIRE_LIMIT = 63
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_word_t  in_word_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_word_t out_word_i,
  output int             fail_count_o,
  output int             pending_o
);

  // Shadow slot table
  logic        armed_q    [NUM_TIMERS];
  logic        periodic_q [NUM_TIMERS];
  logic [31:0] period_q   [NUM_TIMERS];
  logic [63:0] deadline_q [NUM_TIMERS];
  logic [31:0] stamp_q    [NUM_TIMERS];
  logic [31:0] stamp_ctr;
  logic [31:0] min_period;

  out_word_t expected_words[$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_words.size();

  // Queue order: earlier deadline first, then older stamp
  function automatic bit runs_first(int a, int b);
    if (deadline_q[a] != deadline_q[b]) return deadline_q[a] < deadline_q[b];
    return (stamp_ctr - stamp_q[a]) > (stamp_ctr - stamp_q[b]);
  endfunction

  function automatic int next_due();
    int h;
    h = -1;
    for (int i = 0; i < NUM_TIMERS; i++)
      if (armed_q[i] && (h < 0 || runs_first(i, h))) h = i;
    return h;
  endfunction

  function automatic void arm_slot(int i, logic [63:0] dl);
    deadline_q[i] = dl;
    stamp_q[i]    = stamp_ctr;
    stamp_ctr     = stamp_ctr + 32'd1;
    armed_q[i]    = 1'b1;
  endfunction

  function automatic out_word_t word_of(logic st, logic fi, logic [3:0] id, logic pa,
                                        logic [63:0] at, logic la);
    out_word_t w;
    w.status = st; w.fired = fi; w.fired_id = id;
    w.program_alarm = pa; w.alarm_time = at; w.last = la;
    return w;
  endfunction

  function automatic out_word_t closing_word();
    int h;
    h = next_due();
    if (h >= 0) return word_of(1'b0, 1'b0, 4'd0, 1'b1, deadline_q[h], 1'b1);
    return word_of(1'b0, 1'b0, 4'd0, 1'b0, 64'd0, 1'b1);
  endfunction

  // Apply one command to the shadow table and queue its result words
  function automatic void predict_command(in_word_t c);
    int id, h, m, k;
    logic [63:0] dl, base;
    out_word_t idle_word;
    idle_word = word_of(1'b0, 1'b0, 4'd0, 1'b0, 64'd0, 1'b1);
    id = int'(c.timer_id);
    if (c.cmd == CMD_TICK) begin
      k = 0;
      while (k < FIRE_LIMIT) begin
        h = next_due();
        if (h < 0 || deadline_q[h] > c.now_ticks) break;
        armed_q[h] = 1'b0;
        expected_words.push_back(word_of(1'b0, 1'b1, h[3:0], 1'b0, 64'd0, 1'b0));
        k++;
        if (periodic_q[h]) arm_slot(h, deadline_q[h] + {32'd0, period_q[h]});
      end
      expected_words.push_back(closing_word());
    end else if (c.cmd != CMD_ADD && c.cmd != CMD_DEL || id >= NUM_TIMERS) begin
      expected_words.push_back(idle_word);
    end else if (c.cmd == CMD_ADD) begin
      if (c.periodic && c.interval_ticks < min_period) begin
        expected_words.push_back(word_of(1'b1, 1'b0, 4'd0, 1'b0, 64'd0, 1'b1));
      end else begin
        armed_q[id] = 1'b0;
        if (!c.periodic) begin
          periodic_q[id] = 1'b0;
          period_q[id]   = c.interval_ticks;
          dl = c.now_ticks + ((c.interval_ticks == 0) ? 64'd1 : {32'd0, c.interval_ticks});
        end else begin
          base = deadline_q[id];
          if (base == 64'd0) begin
            m = -1;
            for (int j = 0; j < NUM_TIMERS; j++)
              if (armed_q[j] && periodic_q[j] && period_q[j] == c.interval_ticks &&
                  (m < 0 || runs_first(j, m))) m = j;
            base = (m >= 0) ? deadline_q[m] : c.now_ticks;
          end
          periodic_q[id] = 1'b1;
          period_q[id]   = c.interval_ticks;
          dl = base + {32'd0, c.interval_ticks};
        end
        arm_slot(id, dl);
        if (next_due() == id)
          expected_words.push_back(word_of(1'b0, 1'b0, 4'd0, 1'b1, dl, 1'b1));
        else
          expected_words.push_back(idle_word);
      end
    end else begin
      periodic_q[id] = 1'b0;
      if (armed_q[id] && next_due() == id) begin
        armed_q[id] = 1'b0;
        expected_words.push_back(closing_word());
      end else begin
        armed_q[id] = 1'b0;
        expected_words.push_back(idle_word);
      end
    end
  endfunction

  // Compare one result word against the oldest expectation
  task automatic compare_word(out_word_t got);
    out_word_t exp_w;
    if (expected_words.size() == 0) begin
      $error("unexpected result word %h", got);
      fails++;
      return;
    end
    exp_w = expected_words.pop_front();
    if (got.status !== exp_w.status) begin
      $error("status exp %0d got %0d", exp_w.status, got.status); fails++;
    end
    if (got.fired !== exp_w.fired) begin
      $error("fired exp %0d got %0d", exp_w.fired, got.fired); fails++;
    end
    if (got.fired_id !== exp_w.fired_id) begin
      $error("fired_id exp %0d got %0d", exp_w.fired_id, got.fired_id); fails++;
    end
    if (got.program_alarm !== exp_w.program_alarm) begin
      $error("program_alarm exp %0d got %0d", exp_w.program_alarm, got.program_alarm);
      fails++;
    end
    if (got.alarm_time !== exp_w.alarm_time) begin
      $error("alarm_time exp %h got %h", exp_w.alarm_time, got.alarm_time); fails++;
    end
    if (got.last !== exp_w.last) begin
      $error("last exp %0d got %0d", exp_w.last, got.last); fails++;
    end
  endtask

  // Track reset, register writes and both handshakes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed_q[i] = 1'b0; periodic_q[i] = 1'b0; period_q[i] = '0;
        deadline_q[i] = '0; stamp_q[i] = '0;
      end
      stamp_ctr  = '0;
      min_period = '0;
      expected_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_word(out_word_i);
      if (cfg_we_i) min_period = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_command(in_word_i);
    end
  end

  initial fails = 0;

endmodule

`default_nettype wire

### dv/sorted_timer_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit_tb
// Drives directed and random timer commands into the queue under several
// idling phases and register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue_unit_tb;
  import stq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;
  int idle_cycles;
  logic [63:0] clock_now;
  logic        timed_out = 1'b0;

  always #1 clk_i = ~clk_i;

  sorted_timer_queue_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o
  );

  sorted_timer_queue_unit_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_word_i(out_word_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stalls at random, redrawn each falling edge
  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: count cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("sorted_timer_queue_unit_tb: FAIL");
      $finish;
    end
  end

  // Present one command word and hold it until accepted; the caller drops
  // valid later, so back-to-back words see one drive per edge
  task automatic send_cmd(logic [1:0] c, logic [3:0] id, logic per, logic [31:0] ival,
                          logic [63:0] now);
    in_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    w.cmd = c; w.timer_id = id; w.periodic = per;
    w.interval_ticks = ival; w.now_ticks = now;
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Wait for the block to drain, then write the register
  task automatic set_min_period(logic [31:0] v);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random traffic around a moving clock, mostly small intervals
  task automatic random_phase(int n);
    logic [1:0]  c;
    logic [31:0] ival;
    int          r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) c = CMD_ADD;
      else if (r < 55) c = CMD_DEL;
      else if (r < 97) c = CMD_TICK;
      else c = 2'd3;
      r = $urandom_range(99);
      if (r < 80) ival = $urandom_range(60);
      else if (r < 90) ival = $urandom_range(8, 3) * 10;
      else ival = $urandom;
      if ($urandom_range(99) < 90) clock_now = clock_now + $urandom_range(40);
      else if ($urandom_range(1)) clock_now = {$urandom, $urandom};
      send_cmd(c, 4'($urandom_range(15)), 1'($urandom_range(1)), ival, clock_now);
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clock_now      = 64'd1000;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, every command, clamp, alignment, wrap, fire limit
    send_cmd(CMD_TICK, 4'd0, 1'b0, 32'd0, 64'd0);
    send_cmd(CMD_ADD, 4'd0, 1'b0, 32'd0, 64'd10);
    send_cmd(CMD_ADD, 4'd15, 1'b1, 32'd5, 64'd10);
    send_cmd(CMD_ADD, 4'd7, 1'b1, 32'd5, 64'd12);
    send_cmd(CMD_ADD, 4'd3, 1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
    send_cmd(CMD_DEL, 4'd0, 1'b0, 32'd0, 64'd0);
    send_cmd(CMD_DEL, 4'd9, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(2'd3, 4'd15, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_TICK, 4'd15, 1'b1, 32'd0, 64'd30);
    send_cmd(CMD_ADD, 4'd15, 1'b1, 32'd5, 64'd40);
    send_cmd(CMD_ADD, 4'd1, 1'b1, 32'd1, 64'd100);
    send_cmd(CMD_TICK, 4'd0, 1'b0, 32'd0, 64'd400);
    send_cmd(CMD_DEL, 4'd1, 1'b0, 32'd0, 64'd0);
    send_cmd(CMD_DEL, 4'd15, 1'b0, 32'd0, 64'd0);
    send_cmd(CMD_DEL, 4'd7, 1'b0, 32'd0, 64'd0);
    send_cmd(CMD_TICK, 4'd0, 1'b0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);

    set_min_period(32'hFFFF_FFFF);
    send_cmd(CMD_ADD, 4'd2, 1'b1, 32'hFFFF_FFFE, 64'd5);
    send_cmd(CMD_ADD, 4'd2, 1'b1, 32'hFFFF_FFFF, 64'd5);
    send_cmd(CMD_ADD, 4'd4, 1'b1, 32'd0, 64'd5);
    send_cmd(CMD_DEL, 4'd2, 1'b0, 32'd0, 64'd0);

    // Random phases with different idling and register settings
    set_min_period(32'd0);
    random_phase(90);
    send_idle_pct = 54;
    set_min_period(32'd20);
    random_phase(90);
    send_idle_pct = 0; recv_stall_pct = 54;
    set_min_period($urandom_range(60));
    random_phase(90);
    send_idle_pct = 29; recv_stall_pct = 29;
    set_min_period(32'hFFFF_FFFF);
    random_phase(90);
    send_idle_pct = 0; recv_stall_pct = 0;
    set_min_period(32'd1);
    random_phase(100);

    // Drain and report
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0)
      $display("sorted_timer_queue_unit_tb: PASS");
    else
      $display("sorted_timer_queue_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
